// ===== rtl/rws_pkg.sv =====
// Shared types, constants and quality mapping for the signal-strength window statistics block.
package rws_pkg;

    // Input opcodes (carried on tuser)
    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Trend codes
    localparam logic [1:0] TREND_COLLECT  = 2'd0;
    localparam logic [1:0] TREND_STABLE   = 2'd1;
    localparam logic [1:0] TREND_STRONGER = 2'd2;
    localparam logic [1:0] TREND_WEAKER   = 2'd3;

    // Quality classes
    localparam logic [1:0] CLASS_WEAK      = 2'd0;
    localparam logic [1:0] CLASS_FAIR      = 2'd1;
    localparam logic [1:0] CLASS_GOOD      = 2'd2;
    localparam logic [1:0] CLASS_EXCELLENT = 2'd3;

    // dBm breakpoints
    localparam logic signed [7:0] RSSI_FLOOR     = -8'sd100;
    localparam logic signed [7:0] RSSI_CEIL      = -8'sd50;
    localparam logic signed [7:0] RSSI_EXCELLENT = -8'sd55;
    localparam logic signed [7:0] RSSI_GOOD      = -8'sd65;
    localparam logic signed [7:0] RSSI_FAIR      = -8'sd75;
    localparam logic [6:0]        QUALITY_FULL   = 7'd100;

    // Fewest held samples before a trend is formed
    localparam int TREND_MIN_SAMPLES = 6;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [6:0]        pad;
        logic [5:0]        sample_count;
        logic [1:0]        trend_state;
        logic [1:0]        quality_class;
        logic [6:0]        quality_percent;
        logic [7:0]        range_db;
        logic signed [7:0] average_rssi;
        logic signed [7:0] max_rssi;
        logic signed [7:0] min_rssi;
        logic signed [7:0] current_rssi;
    } t_result;

    function automatic logic [6:0] f_quality(input logic signed [7:0] v);
        logic signed [8:0] t;
        logic [6:0]        q;
        t = 9'(v) + 9'sd100;
        if (v <= RSSI_FLOOR) begin
            q = 7'd0;
        end else if (v >= RSSI_CEIL) begin
            q = QUALITY_FULL;
        end else begin
            q = {t[5:0], 1'b0};
        end
        return q;
    endfunction

    function automatic logic [1:0] f_class(input logic signed [7:0] v);
        logic [1:0] c;
        if (v >= RSSI_EXCELLENT) begin
            c = CLASS_EXCELLENT;
        end else if (v >= RSSI_GOOD) begin
            c = CLASS_GOOD;
        end else if (v >= RSSI_FAIR) begin
            c = CLASS_FAIR;
        end else begin
            c = CLASS_WEAK;
        end
        return c;
    endfunction

endpackage

// ===== rtl/rws_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module rws_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);
    import rws_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic             r_neg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[NUM_W-1];
                r_quo  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            end else if (r_busy) begin
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== rtl/rws_scan.sv =====
// History ring memory with write pointer, fill count and a sequential statistics scan.
module rws_scan #(
    parameter int HISTORY_DEPTH = 32,
    parameter int TREND_WINDOW  = 10,
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1),
    localparam int NW     = $clog2(TREND_WINDOW + 1),
    localparam int SUM_W  = 8 + CNT_W,
    localparam int TSUM_W = 8 + NW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_clear,
    input  logic signed [7:0]        i_sample,
    output logic                     o_done,
    output logic        [CNT_W-1:0]  o_count,
    output logic signed [SUM_W-1:0]  o_sum,
    output logic signed [7:0]        o_min,
    output logic signed [7:0]        o_max,
    output logic signed [TSUM_W-1:0] o_old_sum,
    output logic signed [TSUM_W-1:0] o_new_sum,
    output logic        [NW-1:0]     o_half,
    output logic        [NW-1:0]     o_rest
);
    import rws_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [7:0] mem [HISTORY_DEPTH];

    logic [CNT_W-1:0]        r_count;
    logic [AW-1:0]           r_wp;
    logic                    r_busy;
    logic [CNT_W-1:0]        r_idx;
    logic [AW-1:0]           r_addr;
    logic                    r_p_vld;
    logic [CNT_W-1:0]        r_p_idx;
    logic [7:0]              r_rdata;
    logic                    r_done;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [7:0]       r_min;
    logic signed [7:0]       r_max;
    logic signed [TSUM_W-1:0] r_old;
    logic signed [TSUM_W-1:0] r_new;

    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] n_count;
    logic [AW-1:0]    n_wp;
    logic [CNT_W-1:0] last_idx;
    logic [NW-1:0]    win_n;
    logic [NW-1:0]    win_half;
    logic [CNT_W-1:0] win_first;
    logic [CNT_W-1:0] win_split;
    logic signed [7:0] v;

    // Write slot, new fill count and new pointer for an incoming sample
    always_comb begin
        wr_addr = i_clear ? '0 : r_wp;
        if (i_clear) begin
            n_count = CNT_W'(1);
        end else if (r_count == CNT_W'(HISTORY_DEPTH)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CNT_W'(1);
        end
        n_wp = (wr_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_addr + AW'(1);
    end

    // Trend window bounds in chronological scan order
    always_comb begin
        last_idx  = r_count - CNT_W'(1);
        win_n     = (32'(r_count) < TREND_WINDOW) ? NW'(r_count) : NW'(TREND_WINDOW);
        win_half  = win_n >> 1;
        win_first = r_count - CNT_W'(win_n);
        win_split = win_first + CNT_W'(win_half);
        v         = $signed(r_rdata);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            mem[wr_addr] <= i_sample;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= '0;
            r_busy  <= 1'b0;
            r_p_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_p_vld <= r_busy;
            r_p_idx <= r_idx;
            r_done  <= 1'b0;
            if (i_start) begin
                r_count <= n_count;
                r_wp    <= n_wp;
                r_busy  <= 1'b1;
                r_idx   <= '0;
                // oldest entry: slot after the newest once the ring is full
                r_addr  <= (n_count == CNT_W'(HISTORY_DEPTH)) ? n_wp : '0;
                r_sum   <= '0;
                r_min   <= 8'sd127;
                r_max   <= -8'sd128;
                r_old   <= '0;
                r_new   <= '0;
            end else begin
                if (r_busy) begin
                    r_idx  <= r_idx + CNT_W'(1);
                    r_addr <= (r_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_addr + AW'(1);
                    if (r_idx == last_idx) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_p_vld) begin
                    r_sum <= r_sum + SUM_W'(v);
                    if (v < r_min) begin
                        r_min <= v;
                    end
                    if (v > r_max) begin
                        r_max <= v;
                    end
                    if (r_p_idx >= win_first) begin
                        if (r_p_idx < win_split) begin
                            r_old <= r_old + TSUM_W'(v);
                        end else begin
                            r_new <= r_new + TSUM_W'(v);
                        end
                    end
                    if (r_p_idx == last_idx) begin
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_count   = r_count;
    assign o_sum     = r_sum;
    assign o_min     = r_min;
    assign o_max     = r_max;
    assign o_old_sum = r_old;
    assign o_new_sum = r_new;
    assign o_half    = win_half;
    assign o_rest    = win_n - win_half;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= HISTORY_DEPTH)
        else $error("fill count beyond history depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_count != '0)
        else $error("scan running over empty history");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done && !r_p_vld)
        else $error("scan done not a single pulse");

endmodule

// ===== rtl/rssi_window_statistics.sv =====
// Top level of the sliding-window signal-strength statistics block.
// One sample per input beat is written into a ring history held in a
// single-port-write, registered-read memory; a restart opcode (tuser high)
// empties the history before the sample goes in. The block then scans the
// held samples oldest first, one memory read per cycle, to gather sum,
// minimum, maximum and the two trend half sums, and runs up to three
// divisions (window average, older and newer half averages) through one
// shared restoring divider that retires one quotient bit per cycle. The
// divider width is 14 at the default depth of 32; with fewer than six held
// samples the two trend divisions are skipped. The scan length and the
// divider width set how long an item takes. The next sample is taken as
// soon as the current result has moved into the output register, even if
// that result has not yet been taken downstream. The trend threshold
// register may be written at any time the block is idle and takes effect
// on the next sample.
module rssi_window_statistics #(
    parameter int HISTORY_DEPTH = 32,
    parameter int TREND_WINDOW  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: trend threshold
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    // sample input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rssi
    input  logic        s_axis_tuser,   // [0] opcode
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [7:0] current_rssi, [15:8] min_rssi,
                                        // [23:16] max_rssi, [31:24] average_rssi,
                                        // [39:32] range_db, [46:40] quality_percent,
                                        // [48:47] quality_class, [50:49] trend_state,
                                        // [56:51] sample_count, [63:57] zero
);
    import rws_pkg::*;

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int NW     = $clog2(TREND_WINDOW + 1);
    localparam int SUM_W  = 8 + CNT_W;
    localparam int TSUM_W = 8 + NW;
    localparam int DIV_W  = (SUM_W > TSUM_W) ? SUM_W : TSUM_W;
    localparam int DEN_W  = (CNT_W > NW) ? CNT_W : NW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV_AVG,
        S_DIV_OLD,
        S_DIV_NEW,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [5:0]              r_thr;
    logic signed [7:0]       r_cur;
    logic signed [7:0]       r_avg;
    logic signed [7:0]       r_old_avg;
    logic [1:0]              r_trend;
    logic                    r_div_start;
    logic signed [DIV_W-1:0] r_div_num;
    logic [DEN_W-1:0]        r_div_den;
    logic                    r_m_valid;
    t_result                 r_m_data;

    logic                     accept;
    logic                     scan_done;
    logic [CNT_W-1:0]         scan_count;
    logic signed [SUM_W-1:0]  scan_sum;
    logic signed [7:0]        scan_min;
    logic signed [7:0]        scan_max;
    logic signed [TSUM_W-1:0] scan_old;
    logic signed [TSUM_W-1:0] scan_new;
    logic [NW-1:0]            scan_half;
    logic [NW-1:0]            scan_rest;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_quot;
    logic signed [7:0]        quot8;
    logic signed [8:0]        trend_diff;
    logic signed [8:0]        thr_s;
    logic [1:0]               trend_code;
    logic                     out_load;
    t_result                  result;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    rws_scan #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TREND_WINDOW  (TREND_WINDOW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_clear   (s_axis_tuser == OP_RESTART),
        .i_sample  ($signed(s_axis_tdata)),
        .o_done    (scan_done),
        .o_count   (scan_count),
        .o_sum     (scan_sum),
        .o_min     (scan_min),
        .o_max     (scan_max),
        .o_old_sum (scan_old),
        .o_new_sum (scan_new),
        .o_half    (scan_half),
        .o_rest    (scan_rest)
    );

    rws_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Averages of samples always fit in eight bits
    assign quot8 = $signed(div_quot[7:0]);

    // Newer half average against older half average
    always_comb begin
        trend_diff = 9'(quot8) - 9'(r_old_avg);
        thr_s      = $signed({3'b000, r_thr});
        if (trend_diff >= thr_s) begin
            trend_code = TREND_STRONGER;
        end else if (trend_diff <= -thr_s) begin
            trend_code = TREND_WEAKER;
        end else begin
            trend_code = TREND_STABLE;
        end
    end

    // Assemble the result beat from held statistics
    always_comb begin
        result                 = '0;
        result.current_rssi    = r_cur;
        result.min_rssi        = scan_min;
        result.max_rssi        = scan_max;
        result.average_rssi    = r_avg;
        result.range_db        = 8'(scan_max - scan_min);
        result.quality_percent = f_quality(r_cur);
        result.quality_class   = f_class(r_cur);
        result.trend_state     = r_trend;
        result.sample_count    = 6'(scan_count);
    end

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= 6'd3;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            // load a new output beat, else drop the held one once taken
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cur   <= $signed(s_axis_tdata);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= DIV_W'(scan_sum);
                        r_div_den   <= DEN_W'(scan_count);
                        r_state     <= S_DIV_AVG;
                    end
                end
                S_DIV_AVG: begin
                    if (div_done) begin
                        r_avg <= quot8;
                        if (32'(scan_count) < TREND_MIN_SAMPLES) begin
                            r_trend <= TREND_COLLECT;
                            r_state <= S_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_div_num   <= DIV_W'(scan_old);
                            r_div_den   <= DEN_W'(scan_half);
                            r_state     <= S_DIV_OLD;
                        end
                    end
                end
                S_DIV_OLD: begin
                    if (div_done) begin
                        r_old_avg   <= quot8;
                        r_div_start <= 1'b1;
                        r_div_num   <= DIV_W'(scan_new);
                        r_div_den   <= DEN_W'(scan_rest);
                        r_state     <= S_DIV_NEW;
                    end
                end
                S_DIV_NEW: begin
                    if (div_done) begin
                        r_trend <= trend_code;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_m_data  <= result;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("ready held after accepting a sample");

    a_scan_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> r_state == S_SCAN)
        else $error("scan finished outside scan wait");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_AVG || r_state == S_DIV_OLD ||
                      r_state == S_DIV_NEW))
        else $error("division finished outside a division state");

endmodule

// ===== tb/rws_stats_checker.sv =====
`timescale 1ns / 100ps
// Checker for the window statistics block: predicts each result beat and compares it.
module rws_stats_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rssi
    input  logic        i_s_tuser,   // [0] opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // t_result, current_rssi in the lowest bits
    output int          o_fail_count,
    output int          o_pending
);
    import rws_pkg::*;

    localparam int         HIST_DEPTH      = 32;
    localparam int         TREND_SPAN      = 10;
    localparam logic [5:0] THRESHOLD_RESET = 6'd3;
    localparam int         REPORT_LIMIT    = 10;

    logic signed [7:0] hist [HIST_DEPTH];
    int                held_n;
    int                wr_ptr;
    int                thr;
    int                fail_n   = 0;
    int                report_n = 0;
    bit                beat_bad;
    t_result           expected_stats [$];

    // Read the sample at a logical position, oldest first.
    function automatic int held_at(input int logical);
        int phys;
        phys = (held_n == HIST_DEPTH) ? (wr_ptr + logical) % HIST_DEPTH : logical;
        return hist[phys];
    endfunction

    // Add one sample to the history and form the statistics it produces.
    function automatic t_result advance_window(input logic op, input logic signed [7:0] smp);
        t_result r;
        int      cur;
        int      sum;
        int      lo;
        int      hi;
        int      v;
        int      i;
        int      n;
        int      half;
        int      first;
        int      older;
        int      newer;
        int      diff;
        cur = smp;
        if (op == OP_RESTART) begin
            held_n = 0;
            wr_ptr = 0;
        end
        hist[wr_ptr] = smp;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (held_n < HIST_DEPTH) begin
            held_n++;
        end

        lo  = held_at(0);
        hi  = lo;
        sum = 0;
        for (i = 0; i < held_n; i++) begin
            v = held_at(i);
            sum += v;
            if (v < lo) begin
                lo = v;
            end
            if (v > hi) begin
                hi = v;
            end
        end

        r              = '0;
        r.current_rssi = smp;
        r.min_rssi     = 8'(lo);
        r.max_rssi     = 8'(hi);
        r.average_rssi = 8'(sum / held_n);
        r.range_db     = 8'(hi - lo);

        if (cur <= RSSI_FLOOR) begin
            r.quality_percent = '0;
        end else if (cur >= RSSI_CEIL) begin
            r.quality_percent = QUALITY_FULL;
        end else begin
            r.quality_percent = 7'(2 * (cur - RSSI_FLOOR));
        end

        if (cur >= RSSI_EXCELLENT) begin
            r.quality_class = CLASS_EXCELLENT;
        end else if (cur >= RSSI_GOOD) begin
            r.quality_class = CLASS_GOOD;
        end else if (cur >= RSSI_FAIR) begin
            r.quality_class = CLASS_FAIR;
        end else begin
            r.quality_class = CLASS_WEAK;
        end

        // Compare older and newer half averages of the last few samples.
        if (held_n < TREND_MIN_SAMPLES) begin
            r.trend_state = TREND_COLLECT;
        end else begin
            n     = (held_n < TREND_SPAN) ? held_n : TREND_SPAN;
            half  = n / 2;
            first = held_n - n;
            older = 0;
            newer = 0;
            for (i = 0; i < n; i++) begin
                v = held_at(first + i);
                if (i < half) begin
                    older += v;
                end else begin
                    newer += v;
                end
            end
            diff = newer / (n - half) - older / half;
            if (diff >= thr) begin
                r.trend_state = TREND_STRONGER;
            end else if (diff <= -thr) begin
                r.trend_state = TREND_WEAKER;
            end else begin
                r.trend_state = TREND_STABLE;
            end
        end

        r.sample_count = 6'(held_n);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            if (report_n < REPORT_LIMIT) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
            report_n++;
            beat_bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            held_n = 0;
            wr_ptr = 0;
            thr    = THRESHOLD_RESET;
            expected_stats.delete();
        end else begin
            if (i_cfg_we) begin
                thr = i_cfg_wdata;
            end

            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_stats.size() == 0) begin
                    if (report_n < REPORT_LIMIT) begin
                        $display("%0t ns: result beat %h with nothing expected", $time, i_m_tdata);
                    end
                    report_n++;
                    fail_n++;
                end else begin
                    want     = expected_stats.pop_front();
                    beat_bad = 1'b0;
                    check_field("current_rssi", want.current_rssi, got.current_rssi);
                    check_field("min_rssi", want.min_rssi, got.min_rssi);
                    check_field("max_rssi", want.max_rssi, got.max_rssi);
                    check_field("average_rssi", want.average_rssi, got.average_rssi);
                    check_field("range_db", want.range_db, got.range_db);
                    check_field("quality_percent", want.quality_percent, got.quality_percent);
                    check_field("quality_class", want.quality_class, got.quality_class);
                    check_field("trend_state", want.trend_state, got.trend_state);
                    check_field("sample_count", want.sample_count, got.sample_count);
                    if (beat_bad) begin
                        fail_n++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                expected_stats.push_back(advance_window(i_s_tuser, i_s_tdata));
            end
        end
        o_pending    <= expected_stats.size();
        o_fail_count <= fail_n;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, sample stimulus, result back-pressure and verdict.
module testbench;
    import rws_pkg::*;

    localparam int WATCHDOG_LIMIT  = 10000;
    localparam int HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES    = 200;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [5:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rssi
    logic        s_axis_tuser  = 1'b0; // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [7:0] current, [15:8] min, [23:16] max,
                                       // [31:24] average, [39:32] range,
                                       // [46:40] quality percent, [48:47] class,
                                       // [50:49] trend, [56:51] count

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit hold_req    = 1'b0;   // ask the receiver for one long hold-off
    bit steady      = 1'b0;   // no idling on either side while set

    // Samples on and around every quality breakpoint, plus the code extremes.
    int boundary_samples [13] = '{-128, 127, 0, -100, -99, -51, -50,
                                  -55, -56, -65, -66, -75, -76};

    // 4 ns clock period
    always #2 i_clk = ~i_clk;

    rssi_window_statistics DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rws_stats_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: stall about a quarter of the cycles, none while steady is set,
    // and once hold tready low long enough that the block backs up to its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** rssi_window_statistics: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one sample beat and return at the edge that accepts it. tvalid
    // stays high afterwards so back-to-back beats need no second assignment;
    // the caller either offers the next beat at once or calls drain_results.
    task automatic send_sample(input logic op, input logic [7:0] value);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 25) begin
            // Mix short and long gaps so arrivals land on every phase of a scan.
            gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 120);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop tvalid and wait until every expected result has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [5:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One run of samples: usually opened by a restart, then a ramp, a noisy
    // plateau or raw random codes. A stray restart now and then breaks a run.
    task automatic send_run(output int sent);
        int   len;
        int   mode;
        int   level;
        int   step;
        int   k;
        int   value;
        logic op;
        len   = $urandom_range(1, 48);
        mode  = $urandom_range(0, 9);
        level = int'($urandom_range(0, 80)) - 110;
        step  = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) begin
            step = -step;
        end
        for (k = 0; k < len; k++) begin
            if (k == 0) begin
                op = ($urandom_range(0, 3) != 0) ? OP_RESTART : OP_ADD;
            end else begin
                op = ($urandom_range(0, 99) < 3) ? OP_RESTART : OP_ADD;
            end
            if (mode < 2) begin
                value = $urandom_range(0, 255);
            end else if (mode < 5) begin
                level += step;
                if (level > 127) begin
                    level = 127;
                end else if (level < -128) begin
                    level = -128;
                end
                value = level + int'($urandom_range(0, 4)) - 2;
            end else begin
                value = level + int'($urandom_range(0, 8)) - 4;
            end
            send_sample(op, 8'(value));
        end
        sent = len;
    endtask

    initial begin
        int k;
        int phase;
        int sent;
        int run_len;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset threshold: code extremes and breakpoints,
        // the first trend once six samples are held, then a rising and a
        // falling ramp, each opened by a restart.
        for (k = 0; k < 13; k++) begin
            send_sample((k == 0) ? OP_RESTART : OP_ADD, 8'(boundary_samples[k]));
        end
        for (k = 0; k < 6; k++) begin
            send_sample((k == 0) ? OP_RESTART : OP_ADD, 8'(-90 + 5 * k));
        end
        for (k = 0; k < 6; k++) begin
            send_sample((k == 0) ? OP_RESTART : OP_ADD, 8'(-40 - 6 * k));
        end

        // Random part: one threshold per phase, the extremes among them.
        // Change the threshold only once the block has drained.
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       write_threshold(6'd63);
                1:       write_threshold(6'd1);
                2:       write_threshold(6'd0);
                default: write_threshold(6'($urandom_range(1, 62)));
            endcase
            steady <= (phase == 1);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                send_run(run_len);
                sent += run_len;
                if (phase == 0 && sent >= 60) begin
                    hold_req <= 1'b1;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** rssi_window_statistics: PASSED **");
        end else begin
            $display("** rssi_window_statistics: FAILED **");
        end
        $finish;
    end

endmodule
